[hdl/mhpq_pkg.sv]
// Shared widths, result codes and sequencer state type for the max-heap priority queue.
package mhpq_pkg;

  localparam int KEY_W   = 32;
  localparam int COUNT_W = 5;
  localparam int OUT_DATA_W = 72;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [0:0] {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_t;

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_UP      = 7'b0000010,
    S_UP_CMP  = 7'b0000100,
    S_DN_LOAD = 7'b0001000,
    S_DN      = 7'b0010000,
    S_DN_L    = 7'b0100000,
    S_DN_R    = 7'b1000000
  } seq_state_t;

endpackage

[hdl/max_heap_priority_queue.sv]
// Binary max-heap priority queue of signed keys with insert and remove-maximum operations.
// Each input beat is an insert or a remove of the maximum; each gives exactly one result beat
// with a status, the removed key, the new top key and the new count. The keys sit in one
// store with one write port and a registered read port, walked by a small sequencer with signed
// comparators. A rejected operation (insert when full, remove when empty) is answered from idle.
// An insert is accepted, then for each level the new key climbs it reads the parent and moves
// it down, and it writes the key at the root or where a parent stops it. A remove is accepted,
// fetches the last key, then for each level the moved key sinks reads the left child and the
// right child when one exists and moves the larger up, and writes the key where it comes to
// rest without children or where no child is larger. The input is not ready while an operation
// is under way; the result sits in an output register, so the next beat is taken as soon as
// the previous result is taken.
module max_heap_priority_queue import mhpq_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [KEY_W-1:0]      in_tdata,   // [31:0] key_value
  input  logic                  in_tuser,   // [0] kind
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [31:0] removed_key, [63:32] top_key,
                                            // [68:64] entry_count, [71:69] zero
  output logic [1:0]            out_tuser   // [1:0] status
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int EXT_W = CNT_W + 1;
  localparam int PAD_W = OUT_DATA_W - 2 * KEY_W - COUNT_W;

  logic [KEY_W-1:0] heap_mem [CAPACITY];
  logic [KEY_W-1:0] rd_data_r;

  seq_state_t state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] pos_r, pos_nxt;
  logic [IDX_W-1:0] best_idx_r, best_idx_nxt;
  logic             best_child_r, best_child_nxt;
  logic signed [KEY_W-1:0] key_r, key_nxt;
  logic signed [KEY_W-1:0] best_key_r, best_key_nxt;
  logic [KEY_W-1:0] top_r, top_nxt;
  logic [KEY_W-1:0] removed_r, removed_nxt;

  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [KEY_W-1:0] wr_data;
  logic [IDX_W-1:0] rd_addr;

  logic             done;
  status_t          done_status;

  logic             out_valid_r;
  status_t          out_status_r;
  logic [KEY_W-1:0] out_removed_r;
  logic [KEY_W-1:0] out_top_r;
  logic [COUNT_W-1:0] out_count_r;

  logic [EXT_W-1:0] pos_ext, count_ext, left_ext, right_ext;
  logic [IDX_W-1:0] parent_idx;
  logic             in_fire;
  logic             rd_gt_key, rd_gt_best;

  assign in_tready  = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign in_fire    = in_tvalid && in_tready;

  assign pos_ext    = EXT_W'(pos_r);
  assign count_ext  = EXT_W'(count_r);
  assign left_ext   = (pos_ext << 1) + EXT_W'(1);
  assign right_ext  = left_ext + EXT_W'(1);
  assign parent_idx = (pos_r - IDX_W'(1)) >> 1;
  assign rd_gt_key  = $signed(rd_data_r) > key_r;
  assign rd_gt_best = $signed(rd_data_r) > best_key_r;

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    pos_nxt        = pos_r;
    best_idx_nxt   = best_idx_r;
    best_child_nxt = best_child_r;
    key_nxt        = key_r;
    best_key_nxt   = best_key_r;
    removed_nxt    = removed_r;
    wr_en          = 1'b0;
    wr_addr        = pos_r;
    wr_data        = key_r;
    rd_addr        = '0;
    done           = 1'b0;
    done_status    = ST_DONE;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (op_t'(in_tuser) == OP_INSERT) begin
            if (count_r == CNT_W'(CAPACITY)) begin
              done        = 1'b1;
              done_status = ST_FULL;
            end else begin
              key_nxt     = $signed(in_tdata);
              pos_nxt     = IDX_W'(count_r);
              count_nxt   = count_r + CNT_W'(1);
              removed_nxt = '0;
              state_nxt   = S_UP;
            end
          end else begin
            if (count_r == '0) begin
              done        = 1'b1;
              done_status = ST_EMPTY;
            end else begin
              removed_nxt = top_r;
              count_nxt   = count_r - CNT_W'(1);
              rd_addr     = IDX_W'(count_r - CNT_W'(1));
              state_nxt   = S_DN_LOAD;
            end
          end
        end
      end
      S_UP: begin
        if (pos_r == '0) begin
          wr_en     = 1'b1;
          done      = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          rd_addr   = parent_idx;
          state_nxt = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        wr_en = 1'b1;
        if (key_r > $signed(rd_data_r)) begin
          wr_data   = rd_data_r;
          pos_nxt   = parent_idx;
          state_nxt = S_UP;
        end else begin
          done      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_DN_LOAD: begin
        key_nxt   = $signed(rd_data_r);
        pos_nxt   = '0;
        state_nxt = S_DN;
      end
      S_DN: begin
        if (left_ext >= count_ext) begin
          wr_en     = 1'b1;
          done      = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          rd_addr   = IDX_W'(left_ext);
          state_nxt = S_DN_L;
        end
      end
      S_DN_L: begin
        best_child_nxt = rd_gt_key;
        best_key_nxt   = rd_gt_key ? $signed(rd_data_r) : key_r;
        best_idx_nxt   = IDX_W'(left_ext);
        if (right_ext < count_ext) begin
          rd_addr   = IDX_W'(right_ext);
          state_nxt = S_DN_R;
        end else begin
          wr_en = 1'b1;
          if (rd_gt_key) begin
            wr_data   = rd_data_r;
            pos_nxt   = IDX_W'(left_ext);
            state_nxt = S_DN;
          end else begin
            done      = 1'b1;
            state_nxt = S_IDLE;
          end
        end
      end
      S_DN_R: begin
        wr_en = 1'b1;
        if (rd_gt_best) begin
          wr_data   = rd_data_r;
          pos_nxt   = IDX_W'(right_ext);
          state_nxt = S_DN;
        end else if (best_child_r) begin
          wr_data   = best_key_r;
          pos_nxt   = best_idx_r;
          state_nxt = S_DN;
        end else begin
          done      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    top_nxt = (wr_en && wr_addr == '0) ? wr_data : top_r;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      heap_mem[wr_addr] <= wr_data;
    end
    rd_data_r <= heap_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (done) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pos_r        <= pos_nxt;
    best_idx_r   <= best_idx_nxt;
    best_child_r <= best_child_nxt;
    key_r        <= key_nxt;
    best_key_r   <= best_key_nxt;
    top_r        <= top_nxt;
    removed_r    <= removed_nxt;
    if (done) begin
      out_status_r  <= done_status;
      out_removed_r <= (done_status == ST_DONE) ? removed_nxt : '0;
      out_top_r     <= (count_nxt == '0) ? '0 : top_nxt;
      out_count_r   <= COUNT_W'(count_nxt);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {{PAD_W{1'b0}}, out_count_r, out_top_r, out_removed_r};

endmodule
